>>> sv/kct_pkg.sv
// Shared types and codes for the keyed count table.
`default_nettype none
package kct_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_COUNT = 2'd2,
        CMD_TAKE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE
    } t_state;

    localparam int KEY_BITS   = 8;
    localparam int VALUE_BITS = 16;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                match;
        logic                shift;
        logic                update;
        logic [KEY_BITS-1:0] key;
    } t_cell_ctrl;

endpackage
`default_nettype wire

>>> sv/kct_cell.sv
// One table entry: key, count, registered match and neighbour shift path.
`default_nettype none
module kct_cell
    import kct_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cell_ctrl            i_ctrl,
    input  wire logic                  i_valid,
    input  wire logic [KEY_BITS-1:0]   i_prev_key,
    input  wire logic [COUNT_BITS-1:0] i_prev_count,
    input  wire logic [COUNT_BITS-1:0] i_new_count,
    output logic      [KEY_BITS-1:0]   o_key,
    output logic      [COUNT_BITS-1:0] o_count,
    output logic                       o_hit
);

    logic [KEY_BITS-1:0]   r_key;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.match) begin
            r_hit <= i_valid && (r_key == i_ctrl.key);
        end
    end

    // append moves every entry one cell up; an update touches only the hit cell
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_key   <= i_prev_key;
            r_count <= i_prev_count;
        end else if (i_ctrl.update && r_hit) begin
            r_count <= i_new_count;
        end
    end

    assign o_key   = r_key;
    assign o_count = r_count;
    assign o_hit   = r_hit;

endmodule
`default_nettype wire

>>> sv/keyed_count_table.sv
// Keyed count table: chain of entry cells with a command controller.
// An accepted item passes the match state, then the update state, which loads the output register.
// The match state takes no new item; the update state waits while the output register is busy.
// The next item is taken in the update cycle while the output register is free.
// Reset (synchronous, active low) empties the table and sets empty_key to 0.
`default_nettype none
module keyed_count_table
    import kct_pkg::*;
#(
    parameter int ENTRIES    = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,   // empty_key
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // item_key [7:0], amount [23:8]
    input  wire logic [1:0]  s_tuser,       // command [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,       // value [15:0]
    output logic      [0:0]  m_tuser        // accepted [0]
);

    localparam int UW = $clog2(ENTRIES + 1);
    localparam int CW = COUNT_BITS;
    localparam int SW = ((CW > VALUE_BITS) ? CW : VALUE_BITS) + 1;
    localparam logic [SW-1:0] CMAX = SW'({CW{1'b1}});
    localparam logic [SW-1:0] VMAX = SW'({VALUE_BITS{1'b1}});

    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_amt;
    logic [KEY_BITS-1:0]   r_empty_key;
    logic [UW-1:0]         r_used, n_used;
    logic                  r_out_valid;
    logic                  r_out_acc, n_out_acc;
    logic [VALUE_BITS-1:0] r_out_val, n_out_val;

    t_cell_ctrl            w_ctrl;
    logic                  w_accept, w_out_free, w_found, w_append, w_update;
    logic [ENTRIES-1:0]    w_hit;
    logic [KEY_BITS-1:0]   w_key   [ENTRIES];
    logic [CW-1:0]         w_count [ENTRIES];
    logic [CW-1:0]         w_sel_count, w_new_count;
    logic [SW-1:0]         w_have, w_amt, w_sum, w_took;

    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_out_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_key <= '0;
        end else if (i_cfg_we) begin
            r_empty_key <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= t_cmd'(s_tuser);
            r_key <= s_tdata[7:0];
            r_amt <= s_tdata[23:8];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_MATCH;
            S_MATCH:  n_state = S_UPDATE;
            S_UPDATE: if (w_out_free) n_state = w_accept ? S_MATCH : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        w_update = 1'b0;
        unique case (r_state)
            S_IDLE:   s_tready = 1'b1;
            S_MATCH:  s_tready = 1'b0;
            S_UPDATE: begin
                s_tready = w_out_free;
                w_update = w_out_free;
            end
            default:  s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // stored keys are unique, so at most one hit: and-or select
    always_comb begin
        w_sel_count = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_sel_count = w_sel_count | ({CW{w_hit[i]}} & w_count[i]);
        end
    end

    assign w_found = |w_hit;
    assign w_have  = SW'(w_sel_count);
    assign w_amt   = SW'(r_amt);
    assign w_sum   = w_have + w_amt;
    assign w_took  = (w_have < w_amt) ? w_have : w_amt;

    always_comb begin
        n_used      = r_used;
        n_out_acc   = 1'b0;
        n_out_val   = '0;
        w_append    = 1'b0;
        w_new_count = w_sel_count;
        unique case (r_cmd)
            CMD_CLEAR: n_used = '0;
            CMD_ADD: begin
                if ((r_key != r_empty_key) && (r_amt != '0)) begin
                    if (w_found) begin
                        w_new_count = (w_sum > CMAX) ? CW'(CMAX) : CW'(w_sum);
                        n_out_acc   = 1'b1;
                    end else if (r_used < UW'(ENTRIES)) begin
                        w_append  = 1'b1;
                        n_used    = r_used + UW'(1);
                        n_out_acc = 1'b1;
                    end
                end
            end
            CMD_COUNT: begin
                n_out_acc = w_found;
                n_out_val = (w_have > VMAX) ? VALUE_BITS'(VMAX) : VALUE_BITS'(w_have);
            end
            CMD_TAKE: begin
                w_new_count = CW'(w_have - w_took);
                n_out_acc   = w_found;
                n_out_val   = (w_took > VMAX) ? VALUE_BITS'(VMAX) : VALUE_BITS'(w_took);
            end
            default: n_used = r_used;
        endcase
    end

    // new entries enter at cell 0: saturated amount is the count of a fresh entry
    logic [CW-1:0] w_fresh_count;
    assign w_fresh_count = (w_amt > CMAX) ? CW'(CMAX) : CW'(w_amt);

    assign w_ctrl.match  = (r_state == S_MATCH);
    assign w_ctrl.shift  = w_update && w_append;
    assign w_ctrl.update = w_update && !w_append;
    assign w_ctrl.key    = r_key;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [KEY_BITS-1:0] w_prev_key;
        logic [CW-1:0]       w_prev_count;
        if (g == 0) begin : g_head
            assign w_prev_key   = r_key;
            assign w_prev_count = w_fresh_count;
        end else begin : g_link
            assign w_prev_key   = w_key[g-1];
            assign w_prev_count = w_count[g-1];
        end
        kct_cell #(
            .COUNT_BITS(CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_valid      (UW'(g) < r_used),
            .i_prev_key   (w_prev_key),
            .i_prev_count (w_prev_count),
            .i_new_count  (w_new_count),
            .o_key        (w_key[g]),
            .o_count      (w_count[g]),
            .o_hit        (w_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_update) begin
            r_used      <= n_used;
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_out_acc <= n_out_acc;
            r_out_val <= n_out_val;
        end
    end

    assign m_tvalid   = r_out_valid;
    assign m_tdata    = r_out_val;
    assign m_tuser[0] = r_out_acc;

    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> $onehot0(w_hit))
        else $error("more than one entry matched the key");

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(ENTRIES))
        else $error("entry count beyond table size");

    a_accept_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MATCH))
        else $error("accepted item did not enter match cycle");

    a_update_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && !w_out_free) |=> (r_state == S_UPDATE))
        else $error("update left while output register busy");

endmodule
`default_nettype wire
